// File: src/gqi_pkg.sv
// Shared types and constants of the gyro quaternion integrator.
// No dependencies; used by gqi_div, gqi_isqrt and the core.
package gqi_pkg;

    // rad/deg * 1e-6 * 2^54 / 2, scaled half-angle gain
    localparam logic [33:0] HALF_RATE_GAIN = 34'd157205283;
    localparam logic [31:0] HALF_MAX       = 32'hFFFF_FFFF;
    localparam logic [63:0] ONE_Q30        = 64'd1073741824;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    typedef struct packed {
        logic [1:0] qi;
        logic [1:0] gi;
        logic       neg;
    } term_t;

    typedef enum logic [19:0] {
        S_IDLE    = 20'b0000_0000_0000_0000_0001,
        S_DEN     = 20'b0000_0000_0000_0000_0010,
        S_DENSAVE = 20'b0000_0000_0000_0000_0100,
        S_DIVGO   = 20'b0000_0000_0000_0000_1000,
        S_DIVWAIT = 20'b0000_0000_0000_0001_0000,
        S_PMUL    = 20'b0000_0000_0000_0010_0000,
        S_GHI     = 20'b0000_0000_0000_0100_0000,
        S_GLO     = 20'b0000_0000_0000_1000_0000,
        S_GSUM    = 20'b0000_0000_0001_0000_0000,
        S_MULQ    = 20'b0000_0000_0010_0000_0000,
        S_MACC    = 20'b0000_0000_0100_0000_0000,
        S_ABS     = 20'b0000_0000_1000_0000_0000,
        S_NORM    = 20'b0000_0001_0000_0000_0000,
        S_SQ      = 20'b0000_0010_0000_0000_0000,
        S_SQACC   = 20'b0000_0100_0000_0000_0000,
        S_SQRTGO  = 20'b0000_1000_0000_0000_0000,
        S_SQRT    = 20'b0001_0000_0000_0000_0000,
        S_QDIVGO  = 20'b0010_0000_0000_0000_0000,
        S_QDIV    = 20'b0100_0000_0000_0000_0000,
        S_OUT     = 20'b1000_0000_0000_0000_0000
    } state_t;

    // Rate-update terms: c[ci] += sign * q[qi] * g[gi], three per component
    function automatic term_t mulq_term(input logic [1:0] ci, input logic [1:0] ti);
        term_t t;
        case ({ci, ti})
            4'b0000: t = '{qi: 2'd1, gi: 2'd0, neg: 1'b1};
            4'b0001: t = '{qi: 2'd2, gi: 2'd1, neg: 1'b1};
            4'b0010: t = '{qi: 2'd3, gi: 2'd2, neg: 1'b1};
            4'b0100: t = '{qi: 2'd0, gi: 2'd0, neg: 1'b0};
            4'b0101: t = '{qi: 2'd2, gi: 2'd2, neg: 1'b0};
            4'b0110: t = '{qi: 2'd3, gi: 2'd1, neg: 1'b1};
            4'b1000: t = '{qi: 2'd0, gi: 2'd1, neg: 1'b0};
            4'b1001: t = '{qi: 2'd1, gi: 2'd2, neg: 1'b1};
            4'b1010: t = '{qi: 2'd3, gi: 2'd0, neg: 1'b0};
            4'b1100: t = '{qi: 2'd0, gi: 2'd2, neg: 1'b0};
            4'b1101: t = '{qi: 2'd1, gi: 2'd1, neg: 1'b0};
            4'b1110: t = '{qi: 2'd2, gi: 2'd0, neg: 1'b1};
            default: t = '{qi: 2'd0, gi: 2'd0, neg: 1'b0};
        endcase
        return t;
    endfunction

endpackage

// File: src/gqi_div.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
// Depends on gqi_pkg for the status struct.
module gqi_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [63:0]         dividend,
    input  logic [31:0]         divisor,
    output gqi_pkg::unit_stat_t stat,
    output logic [63:0]         quotient
);

    localparam logic [6:0] DIV_STEPS = 7'd64;

    logic        busy_reg;
    logic        done_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] dsr_reg;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;
    logic        fits;

    assign rem_sh  = {rem_reg, quo_reg[63]};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};
    assign fits    = rem_sh >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_STEPS;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[62:0], fits};
            rem_reg <= fits ? rem_sub[31:0] : rem_sh[31:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// File: src/gqi_isqrt.sv
// Bit-pair integer square root of a 64-bit value, one result bit a cycle.
// Depends on gqi_pkg for the status struct.
module gqi_isqrt (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [63:0]         radicand,
    output gqi_pkg::unit_stat_t stat,
    output logic [31:0]         root
);

    localparam logic [5:0] SQRT_STEPS = 6'd32;

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] x_reg;
    logic [63:0] res_reg;
    logic [63:0] one_reg;
    logic [64:0] trial;
    logic        fits;

    assign trial = {1'b0, res_reg} + {1'b0, one_reg};
    assign fits  = {1'b0, x_reg} >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= SQRT_STEPS;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg   <= radicand;
            res_reg <= '0;
            one_reg <= 64'h4000_0000_0000_0000;
        end else if (busy_reg) begin
            if (fits) begin
                x_reg   <= x_reg - trial[63:0];
                res_reg <= (res_reg >> 1) + one_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            one_reg <= one_reg >> 2;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = res_reg[31:0];

endmodule

// File: src/gyro_quaternion_integrator_core.sv
// Gyro quaternion integrator core: sequencer, shared multiplier and state.
// Depends on gqi_pkg, gqi_div and gqi_isqrt.
//
// channel  | dir | handshake          | payload
// ---------+-----+--------------------+-----------------------------------------
// s_       | in  | s_tvalid/s_tready  | s_tdata: sum x, sum y, sum z, count, time
// m_       | out | m_tvalid/m_tready  | m_tdata: quat w, x, y, z
// cfg_     | in  | cfg_valid/cfg_ready| cfg_data: core period
//
// Per item the 64-step shared divider gives up to three averages (none when the
// denominator is zero) and, for a nonzero norm, the 32-step square root is
// followed by four normalising quotients.
// Synchronous active-low reset: identity attitude, previous time zero, period 1.
// s_tready is high only in idle; a finished item waits in the output register
// while the next item is taken, and the core stalls only if that is still full.
module gyro_quaternion_integrator_core #(
    parameter int QUAT_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [31:0] gyro_sum_x, [63:32] gyro_sum_y, [95:64] gyro_sum_z,
    // [111:96] sample_count, [143:112] timestamp_us
    input  logic [143:0]                  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // quat_w, quat_x, quat_y, quat_z, QUAT_WIDTH bits each from bit 0, zero pad
    output logic [((4*QUAT_WIDTH+7)/8)*8-1:0] m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [15:0]                   cfg_data
);

    localparam int OUT_W     = 4 * QUAT_WIDTH;
    localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int WSH       = (QUAT_WIDTH >= 32) ? (QUAT_WIDTH - 32) : (32 - QUAT_WIDTH);

    // Q.(QUAT_WIDTH-2) to Q2.30 and back, floor on the narrowing side
    function automatic logic signed [31:0] to_q30(input logic [QUAT_WIDTH-1:0] v);
        logic signed [63:0] w;
        w = {{(64-QUAT_WIDTH){v[QUAT_WIDTH-1]}}, v};
        if (QUAT_WIDTH >= 32) w = w >>> WSH;
        else                  w = w <<< WSH;
        return w[31:0];
    endfunction

    function automatic logic [QUAT_WIDTH-1:0] from_q30(input logic [31:0] v);
        logic signed [63:0] w;
        w = {{32{v[31]}}, v};
        if (QUAT_WIDTH >= 32) w = w <<< WSH;
        else                  w = w >>> WSH;
        return w[QUAT_WIDTH-1:0];
    endfunction

    gqi_pkg::state_t state_reg, state_next;

    logic [15:0]            period_reg;
    logic [31:0]            prev_time_reg;
    logic [31:0]            sum_reg [3];
    logic [15:0]            count_reg;
    logic [31:0]            dt_reg;
    logic [31:0]            denom_reg;
    logic [31:0]            avg_reg;
    logic [19:0]            lo_reg;
    logic [52:0]            acc_reg;
    logic signed [32:0]     g_reg [3];
    logic [1:0]             idx_reg;
    logic [1:0]             term_reg;
    logic signed [35:0]     c_reg [4];
    logic [34:0]            a_reg [4];
    logic [3:0]             neg_reg;
    logic [63:0]            s2_reg;
    logic [31:0]            r_reg;
    logic [QUAT_WIDTH-1:0]  att_reg [4];
    logic [M_TDATA_W-1:0]   out_reg;
    logic                   m_valid_reg;
    logic signed [67:0]     prod_reg;

    logic signed [33:0]     mul_a;
    logic signed [33:0]     mul_b;
    logic                   mul_en;
    gqi_pkg::term_t         term;
    logic signed [31:0]     q_sel;
    logic [31:0]            dt_mag;
    logic [31:0]            sum_mag;
    logic                   g_neg;
    logic [63:0]            h_sum;
    logic [31:0]            h_val;
    logic signed [35:0]     prod_q30;
    logic [34:0]            or_all;
    logic [63:0]            q_quot;
    logic [30:0]            o_mag;
    logic [31:0]            o_signed;
    logic                   out_free;
    logic                   accept;

    logic                   div_start;
    logic [63:0]            div_dividend;
    logic [31:0]            div_divisor;
    gqi_pkg::unit_stat_t    div_stat;
    logic                   sqrt_start;
    gqi_pkg::unit_stat_t    sqrt_stat;
    logic [31:0]            sqrt_root;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == gqi_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    assign term     = gqi_pkg::mulq_term(idx_reg, term_reg);
    assign q_sel    = to_q30(att_reg[term.qi]);
    assign dt_mag   = dt_reg[31] ? (32'd0 - dt_reg) : dt_reg;
    assign sum_mag  = sum_reg[idx_reg][31] ? (32'd0 - sum_reg[idx_reg]) : sum_reg[idx_reg];
    assign g_neg    = sum_reg[idx_reg][31] ^ dt_reg[31];
    assign h_sum    = {11'd0, acc_reg} + {20'd0, prod_reg[63:20]};
    assign h_val    = (h_sum[63:52] != 12'd0) ? gqi_pkg::HALF_MAX : h_sum[51:20];
    assign prod_q30 = prod_reg[65:30];
    assign or_all   = a_reg[0] | a_reg[1] | a_reg[2] | a_reg[3];
    assign o_mag    = (q_quot > gqi_pkg::ONE_Q30) ? 31'd1073741824 : q_quot[30:0];
    assign o_signed = neg_reg[idx_reg] ? (32'd0 - {1'b0, o_mag}) : {1'b0, o_mag};

    // Shared multiplier operand selection
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (state_reg)
            gqi_pkg::S_DEN: begin
                mul_a = {18'd0, count_reg};
                mul_b = {18'd0, period_reg};
            end
            gqi_pkg::S_PMUL: begin
                mul_a = {2'd0, avg_reg};
                mul_b = {2'd0, dt_mag};
            end
            gqi_pkg::S_GHI: begin
                mul_a = {9'd0, prod_reg[44:20]};
                mul_b = gqi_pkg::HALF_RATE_GAIN;
            end
            gqi_pkg::S_GLO: begin
                mul_a = {14'd0, lo_reg};
                mul_b = gqi_pkg::HALF_RATE_GAIN;
            end
            gqi_pkg::S_MULQ: begin
                mul_a = {{2{q_sel[31]}}, q_sel};
                mul_b = {g_reg[term.gi][32], g_reg[term.gi]};
            end
            gqi_pkg::S_SQ: begin
                mul_a = {3'd0, a_reg[idx_reg][30:0]};
                mul_b = {3'd0, a_reg[idx_reg][30:0]};
            end
            default: mul_en = 1'b0;
        endcase
    end

    // Divider and root are started from dedicated launch states
    always_comb begin
        div_start    = 1'b0;
        div_dividend = {32'd0, sum_mag};
        div_divisor  = denom_reg;
        if (state_reg == gqi_pkg::S_DIVGO) begin
            div_start = (denom_reg != 32'd0);
        end else if (state_reg == gqi_pkg::S_QDIVGO) begin
            div_start    = 1'b1;
            div_dividend = {3'd0, a_reg[idx_reg][30:0], 30'd0};
            div_divisor  = r_reg;
        end
    end

    assign sqrt_start = (state_reg == gqi_pkg::S_SQRTGO);

    gqi_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (q_quot)
    );

    gqi_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (s2_reg),
        .stat     (sqrt_stat),
        .root     (sqrt_root)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gqi_pkg::S_IDLE:    if (accept) state_next = gqi_pkg::S_DEN;
            gqi_pkg::S_DEN:     state_next = gqi_pkg::S_DENSAVE;
            gqi_pkg::S_DENSAVE: state_next = gqi_pkg::S_DIVGO;
            gqi_pkg::S_DIVGO: begin
                state_next = (denom_reg == 32'd0) ? gqi_pkg::S_PMUL : gqi_pkg::S_DIVWAIT;
            end
            gqi_pkg::S_DIVWAIT: if (div_stat.done) state_next = gqi_pkg::S_PMUL;
            gqi_pkg::S_PMUL:    state_next = gqi_pkg::S_GHI;
            gqi_pkg::S_GHI: begin
                if (prod_reg[63:45] != 19'd0) begin
                    state_next = (idx_reg == 2'd2) ? gqi_pkg::S_MULQ : gqi_pkg::S_DIVGO;
                end else begin
                    state_next = gqi_pkg::S_GLO;
                end
            end
            gqi_pkg::S_GLO:     state_next = gqi_pkg::S_GSUM;
            gqi_pkg::S_GSUM: begin
                state_next = (idx_reg == 2'd2) ? gqi_pkg::S_MULQ : gqi_pkg::S_DIVGO;
            end
            gqi_pkg::S_MULQ:    state_next = gqi_pkg::S_MACC;
            gqi_pkg::S_MACC: begin
                if (term_reg == 2'd2 && idx_reg == 2'd3) state_next = gqi_pkg::S_ABS;
                else                                     state_next = gqi_pkg::S_MULQ;
            end
            gqi_pkg::S_ABS:     state_next = gqi_pkg::S_NORM;
            gqi_pkg::S_NORM: begin
                if (or_all == 35'd0)                          state_next = gqi_pkg::S_OUT;
                else if (or_all[34:31] == 4'd0 && or_all[30]) state_next = gqi_pkg::S_SQ;
            end
            gqi_pkg::S_SQ:      state_next = gqi_pkg::S_SQACC;
            gqi_pkg::S_SQACC: begin
                state_next = (idx_reg == 2'd3) ? gqi_pkg::S_SQRTGO : gqi_pkg::S_SQ;
            end
            gqi_pkg::S_SQRTGO:  state_next = gqi_pkg::S_SQRT;
            gqi_pkg::S_SQRT:    if (sqrt_stat.done) state_next = gqi_pkg::S_QDIVGO;
            gqi_pkg::S_QDIVGO:  state_next = gqi_pkg::S_QDIV;
            gqi_pkg::S_QDIV: begin
                if (div_stat.done) begin
                    state_next = (idx_reg == 2'd3) ? gqi_pkg::S_OUT : gqi_pkg::S_QDIVGO;
                end
            end
            gqi_pkg::S_OUT:     if (out_free) state_next = gqi_pkg::S_IDLE;
            default:            state_next = gqi_pkg::S_IDLE;
        endcase
    end

    // Control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= gqi_pkg::S_IDLE;
            period_reg    <= 16'd1;
            prev_time_reg <= '0;
            m_valid_reg   <= 1'b0;
            idx_reg       <= '0;
            term_reg      <= '0;
            att_reg[0]    <= from_q30(32'h4000_0000);
            att_reg[1]    <= '0;
            att_reg[2]    <= '0;
            att_reg[3]    <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) period_reg <= cfg_data;
            if (accept) prev_time_reg <= s_tdata[143:112];

            case (state_reg)
                gqi_pkg::S_DENSAVE: idx_reg <= '0;
                gqi_pkg::S_GHI: begin
                    if (prod_reg[63:45] != 19'd0) begin
                        idx_reg  <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                        term_reg <= '0;
                    end
                end
                gqi_pkg::S_GSUM: begin
                    idx_reg  <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                    term_reg <= '0;
                end
                gqi_pkg::S_MACC: begin
                    if (term_reg == 2'd2) begin
                        term_reg <= '0;
                        idx_reg  <= idx_reg + 2'd1;
                    end else begin
                        term_reg <= term_reg + 2'd1;
                    end
                end
                gqi_pkg::S_NORM: idx_reg <= '0;
                gqi_pkg::S_SQACC: idx_reg <= idx_reg + 2'd1;
                gqi_pkg::S_QDIV: begin
                    if (div_stat.done) begin
                        att_reg[idx_reg] <= from_q30(o_signed);
                        idx_reg          <= idx_reg + 2'd1;
                    end
                end
                default: ;
            endcase

            // zero norm falls back to identity
            if (state_reg == gqi_pkg::S_NORM && or_all == 35'd0) begin
                att_reg[0] <= from_q30(32'h4000_0000);
                att_reg[1] <= '0;
                att_reg[2] <= '0;
                att_reg[3] <= '0;
            end

            // a new result replaces the one being taken in the same cycle
            if (state_reg == gqi_pkg::S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tvalid && m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge aclk) begin
        if (mul_en) prod_reg <= mul_a * mul_b;
        if (accept) begin
            sum_reg[0] <= s_tdata[31:0];
            sum_reg[1] <= s_tdata[63:32];
            sum_reg[2] <= s_tdata[95:64];
            count_reg  <= s_tdata[111:96];
            dt_reg     <= s_tdata[143:112] - prev_time_reg;
        end
        case (state_reg)
            gqi_pkg::S_DENSAVE: denom_reg <= prod_reg[31:0];
            gqi_pkg::S_DIVGO:   avg_reg   <= '0;
            gqi_pkg::S_DIVWAIT: if (div_stat.done) avg_reg <= q_quot[31:0];
            gqi_pkg::S_GHI: begin
                lo_reg <= prod_reg[19:0];
                if (prod_reg[63:45] != 19'd0) begin
                    g_reg[idx_reg] <= g_neg ? (33'sd0 - $signed({1'b0, gqi_pkg::HALF_MAX}))
                                            : $signed({1'b0, gqi_pkg::HALF_MAX});
                end
            end
            gqi_pkg::S_GLO:     acc_reg <= prod_reg[52:0];
            gqi_pkg::S_GSUM: begin
                g_reg[idx_reg] <= g_neg ? (33'sd0 - $signed({1'b0, h_val}))
                                        : $signed({1'b0, h_val});
            end
            gqi_pkg::S_MACC: begin
                c_reg[idx_reg] <= term.neg ? (c_reg[idx_reg] - prod_q30)
                                           : (c_reg[idx_reg] + prod_q30);
            end
            gqi_pkg::S_ABS: begin
                for (int i = 0; i < 4; i++) begin
                    neg_reg[i] <= c_reg[i][35];
                    a_reg[i]   <= c_reg[i][35] ? 35'(36'sd0 - c_reg[i]) : c_reg[i][34:0];
                end
            end
            gqi_pkg::S_NORM: begin
                s2_reg <= '0;
                for (int i = 0; i < 4; i++) begin
                    if (or_all[34:31] != 4'd0) a_reg[i] <= a_reg[i] >> 1;
                    else if (!or_all[30])     a_reg[i] <= a_reg[i] << 1;
                end
            end
            gqi_pkg::S_SQACC:   s2_reg <= s2_reg + prod_reg[63:0];
            gqi_pkg::S_SQRT:    if (sqrt_stat.done) r_reg <= sqrt_root;
            gqi_pkg::S_OUT: begin
                if (out_free) begin
                    out_reg <= M_TDATA_W'({att_reg[3], att_reg[2], att_reg[1], att_reg[0]});
                end
            end
            default: ;
        endcase
        // accumulators start from the stored attitude once all rates are in
        if ((state_reg == gqi_pkg::S_GSUM ||
             (state_reg == gqi_pkg::S_GHI && prod_reg[63:45] != 19'd0)) &&
            idx_reg == 2'd2) begin
            for (int i = 0; i < 4; i++) begin
                c_reg[i] <= 36'(to_q30(att_reg[i]));
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;

    // The core takes one item at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while busy");

    // A result appears only from the output state
    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == gqi_pkg::S_OUT))
        else $error("result raised outside output state");

    // The shared divider is never restarted mid-division
    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

endmodule
